// ----- src/sorted_priority_queue_core_assert.svh -----
// Assertion macros shared by the priority queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define SPQ_ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("sorted priority queue assertion failed");

// Consequent that must hold in the clock after the antecedent.
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sorted priority queue assertion failed");

`endif

// ----- src/spq_pkg.sv -----
`timescale 1ns / 1ps

package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int PRIO_W   = 8;
	localparam int DATA_W   = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_REMOVED  = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef logic [PRIO_W-1:0] prio_t;

	typedef struct packed {
		logic              valid;
		logic [DATA_W-1:0] data;
		prio_t             prio;
	} entry_t;

	// Operation broadcast to every cell of the row.
	typedef struct packed {
		logic              insert;
		logic              remove;
		logic [DATA_W-1:0] data;
		prio_t             prio;
	} op_t;

	// Fit the 8-bit priority field to the stored width.
	function automatic prio_t prio_from_field(logic [7:0] p);
		logic [PRIO_W+7:0] ext;
		ext = {{PRIO_W{1'b0}}, p};
		return ext[PRIO_W-1:0];
	endfunction

	// Fit a stored priority back to the 8-bit field.
	function automatic logic [7:0] prio_to_field(prio_t p);
		logic [PRIO_W+7:0] ext;
		ext = {8'b0, p};
		return ext[7:0];
	endfunction

	// Fit the entry count to its 5-bit field.
	function automatic logic [4:0] count_to_field(logic [CNT_W-1:0] c);
		logic [CNT_W+4:0] ext;
		ext = {5'b0, c};
		return ext[4:0];
	endfunction

endpackage

// ----- src/spq_cell.sv -----
`timescale 1ns / 1ps

module spq_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  spq_pkg::op_t    op,
	input  spq_pkg::entry_t left,
	input  logic            left_keep,
	input  spq_pkg::entry_t right,
	output spq_pkg::entry_t cur,
	output logic            keep
);

	logic              valid_q;
	logic [spq_pkg::DATA_W-1:0] data_q;
	spq_pkg::prio_t    prio_q;
	spq_pkg::entry_t   nxt;
	logic              load;

	assign cur  = '{valid: valid_q, data: data_q, prio: prio_q};
	// Stay in place when held entry is served no later than the new one.
	assign keep = valid_q && (prio_q <= op.prio);

	always_comb begin
		nxt  = cur;
		load = 1'b0;
		if (op.insert && !keep) begin
			load = 1'b1;
			if (left_keep) begin
				nxt = '{valid: 1'b1, data: op.data, prio: op.prio};
			end else begin
				nxt = left;
			end
		end else if (op.remove) begin
			load = 1'b1;
			nxt  = right;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= nxt.data;
			prio_q <= nxt.prio;
		end
	end

endmodule

// ----- src/sorted_priority_queue_core.sv -----
`timescale 1ns / 1ps

// Sorted priority queue of spq_pkg::CAPACITY entries held in a row of cells,
// ordered by ascending priority number (smaller served first, equal priorities
// served in insert order). Each input transfer is an insert (tuser 0) or a
// remove (tuser 1); each produces exactly one output transfer carrying the
// status, the removed entry (zero unless removed) and the entry count after
// the step. The block takes one transfer per cycle while its output is not
// stalled and answers in the next cycle: every cell compares against the
// broadcast priority and shifts to its neighbor in the same clock. The
// output register takes a new transfer in the same cycle as
// its held result leaves; a result that waits on a stalled output blocks
// input until it is taken. An insert into a full queue is dropped with status
// full; a remove from an empty queue reports empty. No clearing pass is
// needed after reset.

`include "sorted_priority_queue_core_assert.svh"

module sorted_priority_queue_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // [31:0] item_data, [39:32] item_priority
	input  logic        s_tuser,  // [0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // [31:0] out_data, [39:32] out_priority,
	                              // [44:40] entry_count, [47:45] zero
	output logic [1:0]  m_tuser   // [1:0] status
);

	localparam int N = spq_pkg::CAPACITY;

	spq_pkg::entry_t cell_w [N];
	logic            keep_w [N];
	spq_pkg::op_t    op;
	logic            accept;
	logic            full;
	logic            empty;
	logic [N-1:0]    valid_vec;
	logic [N:0]      valid_plus;

	logic [spq_pkg::CNT_W-1:0] count_q;
	logic                      m_tvalid_q;
	spq_pkg::status_t          status_q;
	logic [spq_pkg::DATA_W-1:0] out_data_q;
	logic [7:0]                out_prio_q;
	logic [4:0]                out_count_q;

	// Hand the input over whenever the output register is free or draining.
	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// The valid cells form a prefix, so the ends tell full and empty.
	assign full  = cell_w[N-1].valid;
	assign empty = !cell_w[0].valid;

	always_comb begin
		op.insert = accept && (s_tuser == spq_pkg::CMD_INSERT) && !full;
		op.remove = accept && (s_tuser == spq_pkg::CMD_REMOVE) && !empty;
		op.data   = s_tdata[31:0];
		op.prio   = spq_pkg::prio_from_field(s_tdata[39:32]);
	end

	// Row of cells: cell 0 is the head; the new entry enters the first cell
	// that does not keep, and removes shift everything left.
	for (genvar i = 0; i < N; i++) begin : g_cell
		spq_pkg::entry_t left_e;
		spq_pkg::entry_t right_e;
		logic            left_k;
		if (i == 0) begin : g_head
			assign left_e = '0;
			assign left_k = 1'b1;
		end else begin : g_body
			assign left_e = cell_w[i-1];
			assign left_k = keep_w[i-1];
		end
		if (i == N - 1) begin : g_tail
			assign right_e = '0;
		end else begin : g_mid
			assign right_e = cell_w[i+1];
		end
		assign valid_vec[i] = cell_w[i].valid;

		spq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.op        (op),
			.left      (left_e),
			.left_keep (left_k),
			.right     (right_e),
			.cur       (cell_w[i]),
			.keep      (keep_w[i])
		);
	end

	// Track the fill level alongside the cells.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (op.insert) begin
			count_q <= count_q + 1'b1;
		end else if (op.remove) begin
			count_q <= count_q - 1'b1;
		end
	end

	// Output register: hold until the transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (accept) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= '0;
			out_prio_q <= '0;
			if (s_tuser == spq_pkg::CMD_INSERT) begin
				if (full) begin
					status_q    <= spq_pkg::ST_FULL;
					out_count_q <= spq_pkg::count_to_field(count_q);
				end else begin
					status_q    <= spq_pkg::ST_INSERTED;
					out_count_q <= spq_pkg::count_to_field(count_q + 1'b1);
				end
			end else begin
				if (empty) begin
					status_q    <= spq_pkg::ST_EMPTY;
					out_count_q <= spq_pkg::count_to_field(count_q);
				end else begin
					status_q    <= spq_pkg::ST_REMOVED;
					out_data_q  <= cell_w[0].data;
					out_prio_q  <= spq_pkg::prio_to_field(cell_w[0].prio);
					out_count_q <= spq_pkg::count_to_field(count_q - 1'b1);
				end
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {3'b000, out_count_q, out_prio_q, out_data_q};

	assign valid_plus = {1'b0, valid_vec} + 1'b1;

	// Valid cells stay a contiguous prefix from the head.
	`SPQ_ASSERT_ALWAYS(a_valid_prefix, clk, arst_n, $onehot(valid_plus))
	// Fill counter agrees with the cell row.
	`SPQ_ASSERT_ALWAYS(a_count_match, clk, arst_n, int'(count_q) == $countones(valid_vec))
	// A remove from a nonempty queue reports removed next cycle.
	`SPQ_ASSERT_NEXT(a_remove_status, clk, arst_n, op.remove,
		m_tvalid && (m_tuser == spq_pkg::ST_REMOVED))
	// A dropped insert leaves the fill level alone.
	`SPQ_ASSERT_NEXT(a_full_drop, clk, arst_n, accept && (s_tuser == spq_pkg::CMD_INSERT) && full,
		$stable(count_q) && (m_tuser == spq_pkg::ST_FULL))

endmodule
